// ----- rtl/core/spa_pkg.sv -----
// Shared types and constants for the sparse polynomial adder.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package spa_pkg;

   // Capacity of each operand list
   localparam int MAX_TERMS = 16;

   localparam int EXP_W  = 10;
   localparam int COEF_W = 32;
   localparam int SUM_W  = COEF_W + 1;
   localparam int OUT_CNT_W = 6;

   // List fill count and walk pointers reach MAX_TERMS itself
   localparam int CNT_W = $clog2(MAX_TERMS + 1);
   localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   // Merged term count reaches twice the capacity
   localparam int N_W   = $clog2(2 * MAX_TERMS + 1);

   typedef enum logic [1:0] {
      OP_LOAD_A = 2'd0,
      OP_LOAD_B = 2'd1,
      OP_START  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COUNT,
      ST_EMIT,
      ST_EMPTY
   } state_type;

   typedef struct packed {
      logic load_a;
      logic load_b;
      logic walk_clr;
      logic walk_adv;
      logic n_clr;
      logic n_inc;
      logic k_clr;
      logic k_inc;
      logic emit_term;
      logic emit_empty;
      logic lists_clr;
   } cmd_type;

   typedef struct packed {
      logic walk_done;
      logic step_emit;
      logic n_zero;
   } status_type;

endpackage

// ----- rtl/core/spa_ctrl.sv -----
// Controller for the sparse polynomial adder: load decode, count pass, emit pass.
// Depends on spa_pkg; drives the datapath through cmd_type, reads status_type.
`timescale 1ns / 1ps

module spa_ctrl
   import spa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] req_op,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_op)
                  OP_LOAD_A: cmd.load_a = 1'b1;
                  OP_LOAD_B: cmd.load_b = 1'b1;
                  OP_START: begin
                     cmd.walk_clr = 1'b1;
                     cmd.n_clr    = 1'b1;
                     state_in     = ST_COUNT;
                  end
                  default: ;  // unused op: drop
               endcase
            end
         end
         ST_COUNT: begin
            // first pass: walk the merge only to learn the term count
            if (status.walk_done) begin
               if (status.n_zero) begin
                  state_in = ST_EMPTY;
               end else begin
                  cmd.walk_clr = 1'b1;
                  cmd.k_clr    = 1'b1;
                  state_in     = ST_EMIT;
               end
            end else begin
               cmd.walk_adv = 1'b1;
               cmd.n_inc    = status.step_emit;
            end
         end
         ST_EMIT: begin
            if (status.walk_done) begin
               // rewind the walk along with the lists
               cmd.lists_clr = 1'b1;
               cmd.walk_clr  = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.walk_adv  = 1'b1;
               cmd.emit_term = status.step_emit;
               cmd.k_inc     = status.step_emit;
            end
         end
         ST_EMPTY: begin
            cmd.emit_empty = 1'b1;
            cmd.lists_clr  = 1'b1;
            cmd.walk_clr   = 1'b1;
            state_in       = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ----- rtl/core/spa_datapath.sv -----
// Datapath for the sparse polynomial adder: term lists, merge step, result registers.
// Depends on spa_pkg; commanded by spa_ctrl.
`timescale 1ns / 1ps

module spa_datapath
   import spa_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   input  logic [EXP_W-1:0]           req_exponent,
   input  logic signed [COEF_W-1:0]   req_coefficient,
   output status_type                 status,
   output logic                       rsp_valid,
   output logic [EXP_W-1:0]           rsp_term_exponent,
   output logic signed [SUM_W-1:0]    rsp_term_coefficient,
   output logic [OUT_CNT_W-1:0]       rsp_term_count,
   output logic                       rsp_last_term,
   output logic                       rsp_empty_sum
);

   logic [EXP_W-1:0]         a_exp_ff  [MAX_TERMS];
   logic signed [COEF_W-1:0] a_coef_ff [MAX_TERMS];
   logic [EXP_W-1:0]         b_exp_ff  [MAX_TERMS];
   logic signed [COEF_W-1:0] b_coef_ff [MAX_TERMS];

   logic [CNT_W-1:0] count_a_ff, count_a_in;
   logic [CNT_W-1:0] count_b_ff, count_b_in;
   logic [CNT_W-1:0] p_ff, p_in;
   logic [CNT_W-1:0] q_ff, q_in;
   logic [N_W-1:0]   n_ff, n_in;
   logic [N_W-1:0]   k_ff, k_in;

   logic                     rsp_valid_ff;
   logic [EXP_W-1:0]         rsp_exp_ff;
   logic signed [SUM_W-1:0]  rsp_coef_ff;
   logic [OUT_CNT_W-1:0]     rsp_cnt_ff;
   logic                     rsp_last_ff;
   logic                     rsp_empty_ff;

   logic                     a_ok, b_ok;
   logic [EXP_W-1:0]         ea, eb;
   logic signed [SUM_W-1:0]  ca, cb, sum;
   logic                     adv_p, adv_q;
   logic [EXP_W-1:0]         step_exp;
   logic signed [SUM_W-1:0]  step_coef;
   logic                     step_emit;

   // list storage, written on loads only
   always_ff @(posedge clock) begin
      if (cmd.load_a && (count_a_ff < CNT_W'(MAX_TERMS))) begin
         a_exp_ff[count_a_ff[IDX_W-1:0]]  <= req_exponent;
         a_coef_ff[count_a_ff[IDX_W-1:0]] <= req_coefficient;
      end
      if (cmd.load_b && (count_b_ff < CNT_W'(MAX_TERMS))) begin
         b_exp_ff[count_b_ff[IDX_W-1:0]]  <= req_exponent;
         b_coef_ff[count_b_ff[IDX_W-1:0]] <= req_coefficient;
      end
   end

   // one merge step
   always_comb begin
      a_ok = (p_ff < count_a_ff);
      b_ok = (q_ff < count_b_ff);
      ea   = a_exp_ff[p_ff[IDX_W-1:0]];
      eb   = b_exp_ff[q_ff[IDX_W-1:0]];
      ca   = SUM_W'(a_coef_ff[p_ff[IDX_W-1:0]]);
      cb   = SUM_W'(b_coef_ff[q_ff[IDX_W-1:0]]);
      sum  = ca + cb;
      adv_p     = 1'b0;
      adv_q     = 1'b0;
      step_exp  = ea;
      step_coef = ca;
      step_emit = 1'b0;
      priority if (a_ok && b_ok) begin
         if (ea == eb) begin
            step_coef = sum;
            step_emit = (sum != '0);  // cancelled terms drop out
            adv_p     = 1'b1;
            adv_q     = 1'b1;
         end else if (ea < eb) begin
            step_exp  = eb;
            step_coef = cb;
            step_emit = 1'b1;
            adv_q     = 1'b1;
         end else begin
            step_emit = 1'b1;
            adv_p     = 1'b1;
         end
      end else if (a_ok) begin
         step_emit = 1'b1;
         adv_p     = 1'b1;
      end else if (b_ok) begin
         step_exp  = eb;
         step_coef = cb;
         step_emit = 1'b1;
         adv_q     = 1'b1;
      end else begin
         step_emit = 1'b0;
      end
   end

   assign status.walk_done = !a_ok && !b_ok;
   assign status.step_emit = step_emit;
   assign status.n_zero    = (n_ff == '0);

   always_comb begin
      count_a_in = count_a_ff;
      count_b_in = count_b_ff;
      if (cmd.lists_clr) begin
         count_a_in = '0;
         count_b_in = '0;
      end else begin
         if (cmd.load_a && (count_a_ff < CNT_W'(MAX_TERMS))) begin
            count_a_in = count_a_ff + CNT_W'(1);
         end
         if (cmd.load_b && (count_b_ff < CNT_W'(MAX_TERMS))) begin
            count_b_in = count_b_ff + CNT_W'(1);
         end
      end

      p_in = p_ff;
      q_in = q_ff;
      if (cmd.walk_clr) begin
         p_in = '0;
         q_in = '0;
      end else if (cmd.walk_adv) begin
         p_in = p_ff + CNT_W'(adv_p);
         q_in = q_ff + CNT_W'(adv_q);
      end

      n_in = n_ff;
      if (cmd.n_clr) begin
         n_in = '0;
      end else if (cmd.n_inc) begin
         n_in = n_ff + N_W'(1);
      end

      k_in = k_ff;
      if (cmd.k_clr) begin
         k_in = '0;
      end else if (cmd.k_inc) begin
         k_in = k_ff + N_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         p_ff         <= '0;
         q_ff         <= '0;
         n_ff         <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         p_ff         <= p_in;
         q_ff         <= q_in;
         n_ff         <= n_in;
         k_ff         <= k_in;
         rsp_valid_ff <= cmd.emit_term || cmd.emit_empty;
      end
   end

   // result register, loaded only when a transaction goes out
   always_ff @(posedge clock) begin
      if (cmd.emit_empty) begin
         rsp_exp_ff   <= '0;
         rsp_coef_ff  <= '0;
         rsp_cnt_ff   <= '0;
         rsp_last_ff  <= 1'b1;
         rsp_empty_ff <= 1'b1;
      end else if (cmd.emit_term) begin
         rsp_exp_ff   <= step_exp;
         rsp_coef_ff  <= step_coef;
         rsp_cnt_ff   <= OUT_CNT_W'(n_ff);
         rsp_last_ff  <= ((k_ff + N_W'(1)) == n_ff);
         rsp_empty_ff <= 1'b0;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_term_exponent    = rsp_exp_ff;
   assign rsp_term_coefficient = rsp_coef_ff;
   assign rsp_term_count       = rsp_cnt_ff;
   assign rsp_last_term        = rsp_last_ff;
   assign rsp_empty_sum        = rsp_empty_ff;

`ifndef ASSERT_OFF
   a_cnt_a_cap: assert property (@(posedge clock) disable iff (reset)
      count_a_ff <= CNT_W'(MAX_TERMS))
      else $error("list A count exceeds capacity");

   a_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      (p_ff <= count_a_ff) && (q_ff <= count_b_ff))
      else $error("walk pointer ran past its list");

   a_emit_le_count: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_term |-> (k_ff < n_ff))
      else $error("more terms emitted than counted");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |-> (rsp_last_ff && (rsp_cnt_ff == '0)))
      else $error("empty result not marked last");

   a_no_load_in_walk: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_a || cmd.load_b) |-> !cmd.walk_adv)
      else $error("load during merge walk");
`endif

endmodule

// ----- rtl/core/sparse_polynomial_add.sv -----
// Top level of the sparse polynomial adder.
// Depends on spa_pkg, spa_ctrl and spa_datapath.
`timescale 1ns / 1ps

// Usage:
//   A transaction is taken at a rising edge with start high and busy low.
//   req_op selects: load a term into list A, load a term into list B, or
//   start the merge. Loads complete in the accept cycle; busy stays low, so
//   loads may follow back to back. A load into a full list is dropped, as is
//   an unused op code.
//   A start raises busy. The controller walks both lists once to count the
//   surviving terms, then walks them again and emits one term per step, except
//   where equal exponents sum to zero; one step per cycle, and steps <=
//   count_a + count_b. The first result comes out during the second walk,
//   and busy falls once that walk ends. An empty sum gives one result with
//   rsp_empty_sum and rsp_last_term set after the count pass, with busy low.
//   Each result is valid for exactly one cycle on rsp_valid and carries the
//   total term count; the receiver cannot stall. Both lists are emptied when
//   the start completes. Reset empties both lists and returns to idle.
module sparse_polynomial_add
   import spa_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_op,
   input  logic [EXP_W-1:0]          req_exponent,
   input  logic signed [COEF_W-1:0]  req_coefficient,
   output logic                      rsp_valid,
   output logic [EXP_W-1:0]          rsp_term_exponent,
   output logic signed [SUM_W-1:0]   rsp_term_coefficient,
   output logic [OUT_CNT_W-1:0]      rsp_term_count,
   output logic                      rsp_last_term,
   output logic                      rsp_empty_sum
);

   cmd_type    cmd;
   status_type status;

   spa_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   spa_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .req_exponent         (req_exponent),
      .req_coefficient      (req_coefficient),
      .status               (status),
      .rsp_valid            (rsp_valid),
      .rsp_term_exponent    (rsp_term_exponent),
      .rsp_term_coefficient (rsp_term_coefficient),
      .rsp_term_count       (rsp_term_count),
      .rsp_last_term        (rsp_last_term),
      .rsp_empty_sum        (rsp_empty_sum)
   );

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for sparse_polynomial_add: directed and random term lists.
// Depends on spa_pkg and the sparse_polynomial_add RTL; reads no files.
`timescale 1ns / 1ps

module testbench;
   import spa_pkg::*;

   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int DRAIN_CYCLES    = 4 * MAX_TERMS + 16;
   localparam int ITEMS_PER_PHASE = 130;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [EXP_W-1:0]         exponent;
      logic signed [SUM_W-1:0]  coefficient;
      logic [OUT_CNT_W-1:0]     count;
      logic                     last;
      logic                     empty;
   } sum_term_type;

   class poly_sum_scoreboard;
      logic [EXP_W-1:0]         a_exp  [MAX_TERMS];
      logic signed [COEF_W-1:0] a_coef [MAX_TERMS];
      int                       a_len;
      logic [EXP_W-1:0]         b_exp  [MAX_TERMS];
      logic signed [COEF_W-1:0] b_coef [MAX_TERMS];
      int                       b_len;
      sum_term_type             sum_terms_due[$];
      int                       mismatches;
      int                       merges;
      int                       empty_sums;
      int                       terms_seen;
      int                       loads_dropped;

      function new();
         a_len = 0;
         b_len = 0;
         mismatches = 0;
         merges = 0;
         empty_sums = 0;
         terms_seen = 0;
         loads_dropped = 0;
      endfunction

      function int pending();
         return sum_terms_due.size();
      endfunction

      // Returns 1 when the transaction changes the block's state
      function bit note_input(logic [1:0] op, logic [EXP_W-1:0] exponent,
                              logic signed [COEF_W-1:0] coefficient);
         if (op == OP_LOAD_A) begin
            if (a_len == MAX_TERMS) begin
               loads_dropped++;
               return 1'b0;
            end
            a_exp[a_len]  = exponent;
            a_coef[a_len] = coefficient;
            a_len++;
            return 1'b1;
         end
         if (op == OP_LOAD_B) begin
            if (b_len == MAX_TERMS) begin
               loads_dropped++;
               return 1'b0;
            end
            b_exp[b_len]  = exponent;
            b_coef[b_len] = coefficient;
            b_len++;
            return 1'b1;
         end
         if (op == OP_START) begin
            add_lists();
            return 1'b1;
         end
         return 1'b0;
      endfunction

      // Walk both lists by exponent compare, exactly as the hardware does,
      // even when a list is out of order
      function void add_lists();
         sum_term_type            merged[$];
         sum_term_type            t;
         logic signed [SUM_W-1:0] ca;
         logic signed [SUM_W-1:0] cb;
         int                      p;
         int                      q;
         p = 0;
         q = 0;
         while (p < a_len || q < b_len) begin
            t = '0;
            if (p < a_len && q < b_len && a_exp[p] == b_exp[q]) begin
               ca = a_coef[p];
               cb = b_coef[q];
               t.exponent    = a_exp[p];
               t.coefficient = ca + cb;
               p++;
               q++;
               if (t.coefficient != 0) merged.push_back(t);
            end else if (q < b_len && (p == a_len || b_exp[q] > a_exp[p])) begin
               t.exponent    = b_exp[q];
               t.coefficient = b_coef[q];
               q++;
               merged.push_back(t);
            end else begin
               t.exponent    = a_exp[p];
               t.coefficient = a_coef[p];
               p++;
               merged.push_back(t);
            end
         end
         a_len = 0;
         b_len = 0;
         merges++;
         if (merged.size() == 0) begin
            t = '0;
            t.last  = 1'b1;
            t.empty = 1'b1;
            sum_terms_due.push_back(t);
            empty_sums++;
         end else begin
            for (int i = 0; i < merged.size(); i++) begin
               merged[i].count = OUT_CNT_W'(merged.size());
               merged[i].last  = (i == merged.size() - 1);
               sum_terms_due.push_back(merged[i]);
            end
         end
      endfunction

      function void check_result(logic [EXP_W-1:0] exponent,
                                 logic signed [SUM_W-1:0] coefficient,
                                 logic [OUT_CNT_W-1:0] count, logic last, logic empty);
         sum_term_type due;
         if (sum_terms_due.size() == 0) begin
            $error("result with no term due: exponent %0d coefficient %0d",
                   exponent, coefficient);
            mismatches++;
            return;
         end
         due = sum_terms_due.pop_front();
         terms_seen++;
         if (exponent !== due.exponent) begin
            $error("term_exponent: expected %0d, got %0d", due.exponent, exponent);
            mismatches++;
         end
         if (coefficient !== due.coefficient) begin
            $error("term_coefficient: expected %0d, got %0d", due.coefficient, coefficient);
            mismatches++;
         end
         if (count !== due.count) begin
            $error("term_count: expected %0d, got %0d", due.count, count);
            mismatches++;
         end
         if (last !== due.last) begin
            $error("last_term: expected %0b, got %0b", due.last, last);
            mismatches++;
         end
         if (empty !== due.empty) begin
            $error("empty_sum: expected %0b, got %0b", due.empty, empty);
            mismatches++;
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [1:0]               req_op = OP_LOAD_A;
   logic [EXP_W-1:0]         req_exponent = '0;
   logic signed [COEF_W-1:0] req_coefficient = '0;
   logic                     rsp_valid;
   logic [EXP_W-1:0]         rsp_term_exponent;
   logic signed [SUM_W-1:0]  rsp_term_coefficient;
   logic [OUT_CNT_W-1:0]     rsp_term_count;
   logic                     rsp_last_term;
   logic                     rsp_empty_sum;

   poly_sum_scoreboard sb;
   int                 idle_pct = 0;
   int                 accepted_items = 0;
   int                 quiet_cycles = 0;
   bit                 progress;

   sparse_polynomial_add dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_op               (req_op),
      .req_exponent         (req_exponent),
      .req_coefficient      (req_coefficient),
      .rsp_valid            (rsp_valid),
      .rsp_term_exponent    (rsp_term_exponent),
      .rsp_term_coefficient (rsp_term_coefficient),
      .rsp_term_count       (rsp_term_count),
      .rsp_last_term        (rsp_last_term),
      .rsp_empty_sum        (rsp_empty_sum)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Sample pre-edge values; check results before noting a new transaction
   always @(posedge clock) begin
      if (!reset) begin
         progress = 1'b0;
         if (rsp_valid) begin
            sb.check_result(rsp_term_exponent, rsp_term_coefficient, rsp_term_count,
                            rsp_last_term, rsp_empty_sum);
            progress = 1'b1;
         end
         if (start && !busy) begin
            if (sb.note_input(req_op, req_exponent, req_coefficient)) accepted_items++;
            progress = 1'b1;
         end
         quiet_cycles = progress ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   function automatic logic [COEF_W-1:0] pick_coef();
      case ($urandom_range(7))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return COEF_W'($urandom_range(3));
         3: return -COEF_W'($urandom_range(3, 1));
         default: return $urandom();
      endcase
   endfunction

   task automatic idle_sender();
      int gap;
      gap = 0;
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold start until the transaction is taken; leave start high for a follow-on
   task automatic send_item(input logic [1:0] op, input logic [EXP_W-1:0] exponent,
                            input logic [COEF_W-1:0] coefficient);
      start           <= 1'b1;
      req_op          <= op;
      req_exponent    <= exponent;
      req_coefficient <= coefficient;
      @(posedge clock);
      while (busy) @(posedge clock);
      idle_sender();
   endtask

   task automatic drain_sums();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic run_directed();
      // empty lists, start fields set to junk
      send_item(OP_START, 10'h3ff, 32'hffff_ffff);
      // extreme exponents and coefficient sums
      send_item(OP_LOAD_A, 10'h3ff, 32'h7fff_ffff);
      send_item(OP_LOAD_A, 10'h000, 32'h8000_0000);
      send_item(OP_LOAD_B, 10'h3ff, 32'h7fff_ffff);
      send_item(OP_LOAD_B, 10'h000, 32'h8000_0000);
      send_item(OP_START, 10'h155, 32'h5555_5555);
      // full cancellation, with an unused op in between
      send_item(OP_LOAD_A, 10'd5, 32'd7);
      send_item(OP_UNUSED, 10'd5, 32'd123);
      send_item(OP_LOAD_B, 10'd5, -32'sd7);
      send_item(OP_START, 10'h2aa, 32'haaaa_aaaa);
      // out-of-order list A
      send_item(OP_LOAD_A, 10'd3, 32'd1);
      send_item(OP_LOAD_A, 10'd9, 32'd2);
      send_item(OP_LOAD_B, 10'd5, 32'd3);
      send_item(OP_START, '0, '0);
      // A terms left over after B runs out
      send_item(OP_LOAD_A, 10'd10, 32'd1);
      send_item(OP_LOAD_A, 10'd8, 32'd2);
      send_item(OP_LOAD_A, 10'd2, 32'd3);
      send_item(OP_LOAD_B, 10'd9, -32'sd1);
      send_item(OP_START, '0, '0);
      // B only
      send_item(OP_LOAD_B, 10'd512, -32'sd1);
      send_item(OP_START, '0, '0);
   endtask

   // Fill both lists past capacity with disjoint exponents: the sum has the
   // largest term count
   task automatic send_capacity_set();
      for (int i = 0; i < MAX_TERMS + 2; i++)
         send_item(OP_LOAD_A, EXP_W'(1022 - 2 * i), pick_coef());
      for (int i = 0; i < MAX_TERMS + 2; i++)
         send_item(OP_LOAD_B, EXP_W'(1021 - 2 * i), pick_coef());
      send_item(OP_START, '0, '0);
   endtask

   task automatic send_random_set();
      logic [EXP_W-1:0]  a_exps[$];
      logic [EXP_W-1:0]  b_exps[$];
      logic [COEF_W-1:0] a_coefs[$];
      logic [COEF_W-1:0] b_coefs[$];
      logic [COEF_W-1:0] coef;
      int                flavor;
      int                span;
      int                top;
      bit                in_a;
      bit                take_a;
      flavor = $urandom_range(99);
      if (flavor < 80) begin
         // well-formed: walk an exponent window downward, pick terms for A and B
         span = ($urandom_range(3) == 0) ? $urandom_range(48, 13) : $urandom_range(12, 1);
         top  = $urandom_range(1023, span - 1);
         for (int e = top; e > top - span; e--) begin
            in_a = 1'b0;
            if ($urandom_range(1) == 1 && a_exps.size() < MAX_TERMS) begin
               coef = pick_coef();
               a_exps.push_back(EXP_W'(e));
               a_coefs.push_back(coef);
               in_a = 1'b1;
            end
            if ($urandom_range(1) == 1 && b_exps.size() < MAX_TERMS) begin
               // cancel the matching A term now and then
               if (in_a && $urandom_range(2) == 0) coef = -coef;
               else coef = pick_coef();
               b_exps.push_back(EXP_W'(e));
               b_coefs.push_back(coef);
            end
         end
      end else begin
         // broken: arbitrary order, possible overflow
         repeat ($urandom_range(20)) begin
            a_exps.push_back(EXP_W'($urandom_range(1023)));
            a_coefs.push_back(pick_coef());
         end
         repeat ($urandom_range(20)) begin
            b_exps.push_back(EXP_W'($urandom_range(1023)));
            b_coefs.push_back(pick_coef());
         end
      end
      while (a_exps.size() + b_exps.size() != 0) begin
         take_a = (b_exps.size() == 0) || (a_exps.size() != 0 && $urandom_range(1) == 1);
         if (take_a) send_item(OP_LOAD_A, a_exps.pop_front(), a_coefs.pop_front());
         else send_item(OP_LOAD_B, b_exps.pop_front(), b_coefs.pop_front());
         if (flavor >= 80 && $urandom_range(7) == 0)
            send_item(OP_UNUSED, EXP_W'($urandom_range(1023)), $urandom());
      end
      // a broken sequence may leave its terms to the next merge
      if (flavor < 95) send_item(OP_START, EXP_W'($urandom_range(1023)), $urandom());
   endtask

   initial begin
      int idle_plan[3];
      int target;
      idle_plan = '{28, 88, 0};
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idle_pct = idle_plan[0];
      run_directed();
      drain_sums();
      send_capacity_set();
      drain_sums();
      target = accepted_items;
      for (int ph = 0; ph < 3; ph++) begin
         idle_pct = idle_plan[ph];
         target += ITEMS_PER_PHASE;
         while (accepted_items < target) begin
            send_random_set();
            if ($urandom_range(19) == 0) drain_sums();
         end
         drain_sums();
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d expected terms never arrived", sb.pending());
         sb.mismatches++;
      end
      $display("covered %0d transactions, %0d merges (%0d empty sums), %0d dropped loads",
               accepted_items, sb.merges, sb.empty_sums, sb.loads_dropped);
      $display("checked %0d result terms, %0d mismatches", sb.terms_seen, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
